// ===== hw/rtl/smm_pkg.sv =====
// Shared types and codes for the segmented memory manager.
// No dependencies; imported by the controller, datapath, top level and checker.
package smm_pkg;

   // Fixed port field widths.
   localparam int CMD_W    = 3;
   localparam int SEGID_W  = 6;
   localparam int OFF_W    = 8;
   localparam int WORD_W   = 32;
   localparam int COUNT_W  = 9;
   localparam int STATUS_W = 2;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_MAP    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_UNMAP  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_STORE  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_LOAD   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_LDPROG = 3'd4;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOFREE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_TOOBIG = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd3;

   // Controller states, one-hot.
   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_CHECK = 6'b000010,
      S_CLEAR = 6'b000100,
      S_COPY  = 6'b001000,
      S_LOADW = 6'b010000,
      S_RESP  = 6'b100000
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic check;
      logic clear;
      logic copy;
      logic loadw;
      logic respond;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic go_clear;
      logic go_copy;
      logic go_load;
      logic fill_done;
      logic rsp_free;
   } dp_stat_type;

endpackage

// ===== hw/rtl/segmented_memory_manager.sv =====
// Each accepted request beat is checked; a map then runs a zero-fill sweep of
// word_count words, a load latches the read word, and a load program of a nonzero
// segment runs a copy sweep (one word per cycle) into segment 0, before the
// response is registered. Unmap, store, load program of segment 0 and rejected commands go straight to it.
// One command is in flight at a time; the next request is taken once its response is registered.
// Synchronous active-high reset; no clearing pass, segment 0 is mapped at reset.
module segmented_memory_manager #(
   parameter int MAX_SEGMENTS  = 64,
   parameter int SEGMENT_WORDS = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [smm_pkg::CMD_W-1:0]     req_cmd,
   input  logic [smm_pkg::SEGID_W-1:0]   req_seg_id,
   input  logic [smm_pkg::OFF_W-1:0]     req_offset,
   input  logic [smm_pkg::WORD_W-1:0]    req_value,
   input  logic [smm_pkg::COUNT_W-1:0]   req_word_count,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [smm_pkg::SEGID_W-1:0]   rsp_new_seg_id,
   output logic [smm_pkg::WORD_W-1:0]    rsp_read_data,
   output logic [smm_pkg::WORD_W-1:0]    rsp_jump_target,
   output logic [smm_pkg::STATUS_W-1:0]  rsp_status
);
   import smm_pkg::*;

   ctl_cmd_type cmd;
   dp_stat_type stat;

   // Sequencer.
   smm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Storage and checks.
   smm_dpath #(
      .MAX_SEGMENTS  (MAX_SEGMENTS),
      .SEGMENT_WORDS (SEGMENT_WORDS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_cmd         (req_cmd),
      .req_seg_id      (req_seg_id),
      .req_offset      (req_offset),
      .req_value       (req_value),
      .req_word_count  (req_word_count),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_new_seg_id  (rsp_new_seg_id),
      .rsp_read_data   (rsp_read_data),
      .rsp_jump_target (rsp_jump_target),
      .rsp_status      (rsp_status)
   );

endmodule

// ===== hw/rtl/smm_ctrl.sv =====
// Command sequencer of the segmented memory manager.
// Depends on smm_pkg for the state type and the command and status structs.
module smm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  smm_pkg::dp_stat_type stat,
   output smm_pkg::ctl_cmd_type cmd
);
   import smm_pkg::*;

   state_type state_ff, state_in;

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.accept = req_valid;
            if (req_valid) state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            if (stat.go_clear)     state_in = S_CLEAR;
            else if (stat.go_copy) state_in = S_COPY;
            else if (stat.go_load) state_in = S_LOADW;
            else                   state_in = S_RESP;
         end
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.fill_done) state_in = S_RESP;
         end
         S_COPY: begin
            cmd.copy = 1'b1;
            if (stat.fill_done) state_in = S_RESP;
         end
         S_LOADW: begin
            cmd.loadw = 1'b1;
            state_in  = S_RESP;
         end
         S_RESP: begin
            cmd.respond = stat.rsp_free;
            if (stat.rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);

   // State register.
   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

// ===== hw/rtl/smm_dpath.sv =====
// Datapath of the segmented memory manager: word store, size table, free stack,
// allocation counters and the result register. Depends on smm_pkg.
module smm_dpath #(
   parameter int MAX_SEGMENTS  = 64,
   parameter int SEGMENT_WORDS = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  smm_pkg::ctl_cmd_type          cmd,
   output smm_pkg::dp_stat_type          stat,
   input  logic [smm_pkg::CMD_W-1:0]     req_cmd,
   input  logic [smm_pkg::SEGID_W-1:0]   req_seg_id,
   input  logic [smm_pkg::OFF_W-1:0]     req_offset,
   input  logic [smm_pkg::WORD_W-1:0]    req_value,
   input  logic [smm_pkg::COUNT_W-1:0]   req_word_count,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [smm_pkg::SEGID_W-1:0]   rsp_new_seg_id,
   output logic [smm_pkg::WORD_W-1:0]    rsp_read_data,
   output logic [smm_pkg::WORD_W-1:0]    rsp_jump_target,
   output logic [smm_pkg::STATUS_W-1:0]  rsp_status
);
   import smm_pkg::*;

   localparam int SEG_W  = $clog2(MAX_SEGMENTS);
   localparam int SZ_W   = $clog2(SEGMENT_WORDS + 1);
   localparam int ADDR_W = (MAX_SEGMENTS * SEGMENT_WORDS > 1) ?
                           $clog2(MAX_SEGMENTS * SEGMENT_WORDS) : 1;
   localparam int DEPTH  = MAX_SEGMENTS * SEGMENT_WORDS;

   // Memories.
   logic [WORD_W-1:0] word_mem [DEPTH];
   logic [SZ_W:0]     size_mem [MAX_SEGMENTS];
   logic [SEG_W-1:0]  stack_mem [MAX_SEGMENTS];

   // Latched command fields.
   logic [CMD_W-1:0]   cur_cmd_ff;
   logic [SEGID_W-1:0] cur_seg_ff;
   logic [OFF_W-1:0]   cur_off_ff;
   logic [WORD_W-1:0]  cur_val_ff;
   logic [COUNT_W-1:0] cur_cnt_ff;

   // Allocation state.
   logic [SEG_W:0]   free_count_ff;
   logic [SEG_W:0]   next_fresh_ff;
   logic [SZ_W-1:0]  size0_ff;

   // Sweep state for clear and copy.
   logic [SZ_W-1:0]   k_ff;
   logic [SZ_W-1:0]   len_ff;
   logic [ADDR_W-1:0] base_ff;
   logic              cp_vld_ff;
   logic [SZ_W-1:0]   wk_ff;

   // Memory read registers.
   logic [WORD_W-1:0] word_rd_ff;
   logic [SZ_W:0]     size_rd_ff;
   logic [SEG_W-1:0]  stack_rd_ff;

   // Pending result and output register.
   logic [SEGID_W-1:0]  res_id_ff;
   logic [WORD_W-1:0]   res_rd_ff;
   logic [WORD_W-1:0]   res_jt_ff;
   logic [STATUS_W-1:0] res_st_ff;
   logic                rsp_valid_ff;
   logic [SEGID_W-1:0]  rsp_id_ff;
   logic [WORD_W-1:0]   rsp_rd_ff;
   logic [WORD_W-1:0]   rsp_jt_ff;
   logic [STATUS_W-1:0] rsp_st_ff;

   // Check-cycle decode.
   logic [31:0]       seg32;
   logic [SEG_W-1:0]  seg_idx;
   logic              in_range;
   logic              mapped;
   logic [SZ_W-1:0]   seg_size;
   logic              access_ok;
   logic              too_big;
   logic              have_free;
   logic              fresh_ok;
   logic [SEG_W-1:0]  new_id;
   logic [ADDR_W-1:0] seg_base;
   logic [ADDR_W-1:0] new_base;
   logic [ADDR_W-1:0] acc_addr;
   logic [STATUS_W-1:0] st;
   logic map_ok, unmap_ok, store_ok, load_ok, ldp_ok, ldp_copy;

   // Segment lookup and command checks.
   always_comb begin
      seg32     = 32'(cur_seg_ff);
      seg_idx   = seg32[SEG_W-1:0];
      in_range  = seg32 < 32'(MAX_SEGMENTS);
      mapped    = in_range && ((seg32 == 32'd0) ||
                  ((seg32 < 32'(next_fresh_ff)) && size_rd_ff[SZ_W]));
      seg_size  = (seg32 == 32'd0) ? size0_ff : size_rd_ff[SZ_W-1:0];
      access_ok = mapped && (32'(cur_off_ff) < 32'(seg_size));
      too_big   = 32'(cur_cnt_ff) > 32'(SEGMENT_WORDS);
      have_free = free_count_ff != '0;
      fresh_ok  = 32'(next_fresh_ff) < 32'(MAX_SEGMENTS);
      new_id    = have_free ? stack_rd_ff : next_fresh_ff[SEG_W-1:0];
      seg_base  = ADDR_W'(seg_idx) * ADDR_W'(SEGMENT_WORDS);
      new_base  = ADDR_W'(new_id) * ADDR_W'(SEGMENT_WORDS);
      acc_addr  = seg_base + ADDR_W'(cur_off_ff);
      map_ok    = 1'b0;
      unmap_ok  = 1'b0;
      store_ok  = 1'b0;
      load_ok   = 1'b0;
      ldp_ok    = 1'b0;
      st        = ST_RANGE;
      case (cur_cmd_ff)
         CMD_MAP: begin
            if (too_big)                     st = ST_TOOBIG;
            else if (have_free || fresh_ok) begin
               st = ST_OK; map_ok = 1'b1;
            end else                         st = ST_NOFREE;
         end
         CMD_UNMAP: begin
            if ((seg32 != 32'd0) && mapped &&
                (32'(free_count_ff) < 32'(MAX_SEGMENTS))) begin
               st = ST_OK; unmap_ok = 1'b1;
            end
         end
         CMD_STORE: begin
            if (access_ok) begin
               st = ST_OK; store_ok = 1'b1;
            end
         end
         CMD_LOAD: begin
            if (access_ok) begin
               st = ST_OK; load_ok = 1'b1;
            end
         end
         CMD_LDPROG: begin
            if (mapped) begin
               st = ST_OK; ldp_ok = 1'b1;
            end
         end
         default: st = ST_RANGE;
      endcase
      ldp_copy = ldp_ok && (seg32 != 32'd0);
   end

   assign stat.go_clear  = map_ok;
   assign stat.go_copy   = ldp_copy;
   assign stat.go_load   = load_ok;
   assign stat.fill_done = (k_ff == len_ff) && !cp_vld_ff;
   assign stat.rsp_free  = !rsp_valid_ff || rsp_ready;

   // Word store port selection.
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = acc_addr;
      wr_data = cur_val_ff;
      rd_en   = 1'b0;
      rd_addr = acc_addr;
      if (cmd.check && store_ok) begin
         wr_en = 1'b1;
      end else if (cmd.clear && (k_ff != len_ff)) begin
         wr_en   = 1'b1;
         wr_addr = base_ff + ADDR_W'(k_ff);
         wr_data = '0;
      end else if (cmd.copy && cp_vld_ff) begin
         wr_en   = 1'b1;
         wr_addr = ADDR_W'(wk_ff);
         wr_data = word_rd_ff;
      end
      if (cmd.check && load_ok) begin
         rd_en = 1'b1;
      end else if (cmd.copy && (k_ff != len_ff)) begin
         rd_en   = 1'b1;
         rd_addr = base_ff + ADDR_W'(k_ff);
      end
   end

   // Word store memory.
   always_ff @(posedge clock) begin
      if (wr_en) word_mem[wr_addr] <= wr_data;
      if (rd_en) word_rd_ff <= word_mem[rd_addr];
   end

   // Size table and free stack memories; read at accept, written at check.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         size_rd_ff  <= size_mem[SEG_W'(req_seg_id)];
         stack_rd_ff <= stack_mem[SEG_W'(free_count_ff - 1'b1)];
      end
      if (cmd.check && map_ok)   size_mem[new_id] <= {1'b1, SZ_W'(cur_cnt_ff)};
      if (cmd.check && unmap_ok) size_mem[seg_idx] <= '0;
      if (cmd.check && unmap_ok) stack_mem[free_count_ff[SEG_W-1:0]] <= seg_idx;
   end

   // Latched fields, sweep payload and pending result.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cur_cmd_ff <= req_cmd;
         cur_seg_ff <= req_seg_id;
         cur_off_ff <= req_offset;
         cur_val_ff <= req_value;
         cur_cnt_ff <= req_word_count;
      end
      if (cmd.check) begin
         res_id_ff <= map_ok ? SEGID_W'(new_id) : '0;
         res_rd_ff <= '0;
         res_jt_ff <= ldp_ok ? cur_val_ff : '0;
         res_st_ff <= st;
         base_ff   <= map_ok ? new_base : seg_base;
         len_ff    <= map_ok ? SZ_W'(cur_cnt_ff) : seg_size;
         k_ff      <= '0;
      end else if ((cmd.clear || cmd.copy) && (k_ff != len_ff)) begin
         k_ff <= k_ff + 1'b1;
      end
      if (cmd.copy) wk_ff <= k_ff;
      if (cmd.loadw) res_rd_ff <= word_rd_ff;
      if (cmd.respond) begin
         rsp_id_ff <= res_id_ff;
         rsp_rd_ff <= res_rd_ff;
         rsp_jt_ff <= res_jt_ff;
         rsp_st_ff <= res_st_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         free_count_ff <= '0;
         next_fresh_ff <= (SEG_W + 1)'(1);
         size0_ff      <= SZ_W'(SEGMENT_WORDS);
         cp_vld_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.check && map_ok) begin
            if (have_free) free_count_ff <= free_count_ff - 1'b1;
            else           next_fresh_ff <= next_fresh_ff + 1'b1;
         end
         if (cmd.check && unmap_ok) free_count_ff <= free_count_ff + 1'b1;
         if (cmd.check && ldp_copy) size0_ff <= seg_size;
         cp_vld_ff <= cmd.copy && (k_ff != len_ff);
         if (cmd.respond)     rsp_valid_ff <= 1'b1;
         else if (rsp_ready)  rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_new_seg_id  = rsp_id_ff;
   assign rsp_read_data   = rsp_rd_ff;
   assign rsp_jump_target = rsp_jt_ff;
   assign rsp_status      = rsp_st_ff;

endmodule

// ===== hw/rtl/smm_checker.sv =====
// Port-level checks for the segmented memory manager, bound to the top level.
// Depends on smm_pkg for field widths and status codes.
module smm_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [smm_pkg::SEGID_W-1:0]   rsp_new_seg_id,
   input logic [smm_pkg::WORD_W-1:0]    rsp_read_data,
   input logic [smm_pkg::WORD_W-1:0]    rsp_jump_target,
   input logic [smm_pkg::STATUS_W-1:0]  rsp_status
);
   import smm_pkg::*;

   // A stalled response beat holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_read_data))
      else $error("response changed while stalled");

   // Failed commands return all-zero data fields.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |->
      (rsp_new_seg_id == '0) && (rsp_read_data == '0) && (rsp_jump_target == '0))
      else $error("error response carries data");

   // A new segment identifier comes only from a map, which returns no data.
   a_map_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_new_seg_id != '0) |->
      (rsp_read_data == '0) && (rsp_jump_target == '0))
      else $error("map response carries data");

   // Nothing is returned in the first cycle out of reset, and a request can be taken.
   a_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid && req_ready)
      else $error("bad state after reset");

endmodule

bind segmented_memory_manager smm_checker u_smm_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_new_seg_id  (rsp_new_seg_id),
   .rsp_read_data   (rsp_read_data),
   .rsp_jump_target (rsp_jump_target),
   .rsp_status      (rsp_status)
);

// ===== test/segmented_memory_manager_test.sv =====
// Self-checking testbench for the segmented memory manager.
// Depends on smm_pkg and the segmented_memory_manager top level only.
module segmented_memory_manager_test;
   timeunit 1ns;
   timeprecision 1ps;
   import smm_pkg::*;

   localparam int NSEG  = 64;
   localparam int NWORD = 256;
   localparam int RANDOM_ITEMS = 800;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [SEGID_W-1:0] seg;
      logic [OFF_W-1:0]   off;
      logic [WORD_W-1:0]  val;
      logic [COUNT_W-1:0] cnt;
   } mm_cmd_t;

   typedef struct packed {
      logic [SEGID_W-1:0]  new_id;
      logic [WORD_W-1:0]   rdata;
      logic [WORD_W-1:0]   jtarget;
      logic [STATUS_W-1:0] status;
   } mm_rsp_t;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [CMD_W-1:0]    req_cmd = '0;
   logic [SEGID_W-1:0]  req_seg_id = '0;
   logic [OFF_W-1:0]    req_offset = '0;
   logic [WORD_W-1:0]   req_value = '0;
   logic [COUNT_W-1:0]  req_word_count = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [SEGID_W-1:0]  rsp_new_seg_id;
   logic [WORD_W-1:0]   rsp_read_data;
   logic [WORD_W-1:0]   rsp_jump_target;
   logic [STATUS_W-1:0] rsp_status;

   segmented_memory_manager uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_cmd(req_cmd), .req_seg_id(req_seg_id), .req_offset(req_offset),
      .req_value(req_value), .req_word_count(req_word_count),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_new_seg_id(rsp_new_seg_id), .rsp_read_data(rsp_read_data),
      .rsp_jump_target(rsp_jump_target), .rsp_status(rsp_status)
   );

   // Clock with a 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Shadow copy of the segment table and word store.
   logic              seg_live [NSEG];
   int unsigned       seg_len  [NSEG];
   logic [5:0]        free_ids [NSEG];
   int unsigned       free_depth;
   int unsigned       fresh_id;
   logic [31:0]       words    [NSEG*NWORD];
   logic              seg0_set [NWORD];

   mm_cmd_t pending_cmds [$];
   mm_rsp_t expected_rsps [$];
   mm_cmd_t held_cmd;
   int unsigned issued = 0, accepted = 0, checked = 0, errors = 0;
   int unsigned status_seen [4];
   bit stimulus_done = 0;
   int unsigned burst_left = 0;
   int unsigned gap_left = 0;

   // Applies one command to the shadow state and returns its response.
   function automatic mm_rsp_t execute_cmd(mm_cmd_t c);
      mm_rsp_t r;
      int unsigned id;
      r = '0;
      r.status = ST_OK;
      case (c.cmd)
         CMD_MAP: begin
            if (c.cnt > NWORD) begin
               r.status = ST_TOOBIG;
            end else if (free_depth == 0 && fresh_id >= NSEG) begin
               r.status = ST_NOFREE;
            end else begin
               if (free_depth > 0) begin
                  free_depth--;
                  id = 32'(free_ids[free_depth]);
               end else begin
                  id = fresh_id;
                  fresh_id++;
               end
               for (int w = 0; w < NWORD; w++) words[id*NWORD + w] = '0;
               seg_len[id] = 32'(c.cnt);
               seg_live[id] = 1'b1;
               r.new_id = id[5:0];
            end
         end
         CMD_UNMAP: begin
            if (c.seg == 0 || !seg_live[c.seg] || free_depth >= NSEG) begin
               r.status = ST_RANGE;
            end else begin
               seg_live[c.seg] = 1'b0;
               seg_len[c.seg] = 0;
               free_ids[free_depth] = c.seg;
               free_depth++;
            end
         end
         CMD_STORE: begin
            if (!seg_live[c.seg] || c.off >= seg_len[c.seg]) begin
               r.status = ST_RANGE;
            end else begin
               words[c.seg*NWORD + c.off] = c.val;
               if (c.seg == 0) seg0_set[c.off] = 1'b1;
            end
         end
         CMD_LOAD: begin
            if (!seg_live[c.seg] || c.off >= seg_len[c.seg]) r.status = ST_RANGE;
            else r.rdata = words[c.seg*NWORD + c.off];
         end
         CMD_LDPROG: begin
            if (c.seg != 0 && !seg_live[c.seg]) begin
               r.status = ST_RANGE;
            end else begin
               if (c.seg != 0) begin
                  for (int w = 0; w < seg_len[c.seg]; w++) begin
                     words[w] = words[c.seg*NWORD + w];
                     seg0_set[w] = 1'b1;
                  end
                  seg_len[0] = seg_len[c.seg];
               end
               r.jtarget = c.val;
            end
         end
         default: r.status = ST_RANGE;
      endcase
      return r;
   endfunction

   // Driver: offers queued commands in bursts separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_rsps.push_back(execute_cmd(held_cmd));
            accepted++;
         end
         if (!(req_valid && !req_ready)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
               held_cmd = pending_cmds.pop_front();
               req_cmd        <= held_cmd.cmd;
               req_seg_id     <= held_cmd.seg;
               req_offset     <= held_cmd.off;
               req_value      <= held_cmd.val;
               req_word_count <= held_cmd.cnt;
               req_valid      <= 1'b1;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 12);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each response beat and stalls on its own pattern.
   int unsigned hold_left = 0;
   int unsigned cycle_count = 0;
   bit long_hold_done = 0;
   always @(posedge clock) begin
      mm_rsp_t exp_r;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         cycle_count++;
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $error("response beat with nothing expected");
               errors++;
            end else begin
               exp_r = expected_rsps.pop_front();
               checked++;
               status_seen[exp_r.status]++;
               if (rsp_new_seg_id !== exp_r.new_id) begin
                  $error("new_seg_id: expected %0d, got %0d", exp_r.new_id, rsp_new_seg_id);
                  errors++;
               end
               if (rsp_read_data !== exp_r.rdata) begin
                  $error("read_data: expected %h, got %h", exp_r.rdata, rsp_read_data);
                  errors++;
               end
               if (rsp_jump_target !== exp_r.jtarget) begin
                  $error("jump_target: expected %h, got %h", exp_r.jtarget, rsp_jump_target);
                  errors++;
               end
               if (rsp_status !== exp_r.status) begin
                  $error("status: expected %0d, got %0d", exp_r.status, rsp_status);
                  errors++;
               end
            end
         end
         // One long hold-off mid-run, otherwise alternating stall patterns.
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!long_hold_done && accepted >= 300) begin
            long_hold_done = 1;
            hold_left = 400;
            rsp_ready <= 1'b0;
         end else if ((cycle_count / 128) % 3 == 0) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(0, 3) != 0);
         end
      end
   end

   // Queues one command once every earlier one is accepted, so the shadow
   // state is current; a load of a never-written word of segment 0 turns
   // into a store of that word.
   task automatic issue_cmd(input mm_cmd_t c);
      @(negedge clock);
      while (!(pending_cmds.size() == 0 && !req_valid && issued == accepted))
         @(negedge clock);
      if (c.cmd == CMD_LOAD && c.seg == 0 && c.off < seg_len[0] && !seg0_set[c.off])
         c.cmd = CMD_STORE;
      pending_cmds.push_back(c);
      issued++;
   endtask

   function automatic mm_cmd_t make_cmd(int unsigned op, int unsigned seg, int unsigned off,
                                         logic [31:0] val, int unsigned cnt);
      mm_cmd_t c;
      c.cmd = op[CMD_W-1:0];
      c.seg = seg[SEGID_W-1:0];
      c.off = off[OFF_W-1:0];
      c.val = val;
      c.cnt = cnt[COUNT_W-1:0];
      return c;
   endfunction

   // Picks a mapped segment, or any identifier now and then.
   function automatic int unsigned pick_seg();
      int unsigned live_ids [$];
      for (int s = 0; s < NSEG; s++) if (seg_live[s]) live_ids.push_back(s);
      if ($urandom_range(0, 4) == 0 || live_ids.size() == 0) return $urandom_range(0, NSEG-1);
      return live_ids[$urandom_range(0, live_ids.size()-1)];
   endfunction

   // Random command, map-heavy or unmap-heavy depending on the phase.
   function automatic mm_cmd_t random_cmd(int unsigned n);
      mm_cmd_t c;
      int unsigned r, s, k;
      c = make_cmd($urandom_range(0, 7), $urandom_range(0, 63), $urandom_range(0, 255),
                   $urandom, $urandom_range(0, 511));
      r = $urandom_range(0, 99);
      s = pick_seg();
      c.seg = s[SEGID_W-1:0];
      if (seg_len[s] > 0 && $urandom_range(0, 6) != 0)
         c.off = OFF_W'($urandom_range(0, seg_len[s]-1));
      if (r < (((n / 200) % 2 == 0) ? 30 : 12)) begin
         c.cmd = CMD_MAP;
         k = $urandom_range(0, 19);
         if (k < 14) c.cnt = COUNT_W'($urandom_range(0, 8));
         else if (k < 17) c.cnt = COUNT_W'($urandom_range(0, NWORD));
         else if (k < 19) c.cnt = COUNT_W'(NWORD);
         else c.cnt = COUNT_W'($urandom_range(NWORD+1, 511));
      end else if (r < 45) begin
         c.cmd = CMD_UNMAP;
      end else if (r < 70) begin
         c.cmd = CMD_STORE;
      end else if (r < 92) begin
         c.cmd = CMD_LOAD;
      end else if (r < 97) begin
         c.cmd = CMD_LDPROG;
      end
      return c;
   endfunction

   // Stimulus, then the end-of-run wait and verdict.
   initial begin
      mm_cmd_t directed [$];
      for (int s = 0; s < NSEG; s++) begin
         seg_live[s] = (s == 0);
         seg_len[s] = (s == 0) ? NWORD : 0;
      end
      for (int w = 0; w < NWORD; w++) seg0_set[w] = 1'b0;
      free_depth = 0;
      fresh_id = 1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part: field extremes, every command and each corner case.
      directed.push_back(make_cmd(CMD_MAP, 0, 0, '1, 0));
      directed.push_back(make_cmd(CMD_MAP, 63, 255, 0, NWORD));
      directed.push_back(make_cmd(CMD_MAP, 0, 0, 0, NWORD+1));
      directed.push_back(make_cmd(CMD_MAP, 0, 0, 0, 511));
      directed.push_back(make_cmd(CMD_STORE, 0, 255, 32'hFFFF_FFFF, 0));
      directed.push_back(make_cmd(CMD_LOAD, 0, 255, 0, 0));
      directed.push_back(make_cmd(CMD_STORE, 0, 0, 32'h0, 511));
      directed.push_back(make_cmd(CMD_LOAD, 0, 0, '1, 0));
      directed.push_back(make_cmd(CMD_STORE, 2, 255, 32'hA5A5_5A5A, 0));
      directed.push_back(make_cmd(CMD_LOAD, 2, 255, 0, 0));
      directed.push_back(make_cmd(CMD_LOAD, 1, 0, 0, 0));
      directed.push_back(make_cmd(CMD_LOAD, 63, 0, 0, 0));
      directed.push_back(make_cmd(CMD_STORE, 63, 0, 1, 0));
      directed.push_back(make_cmd(CMD_UNMAP, 0, 0, 0, 0));
      directed.push_back(make_cmd(CMD_UNMAP, 40, 0, 0, 0));
      directed.push_back(make_cmd(CMD_LDPROG, 0, 0, 32'hDEAD_BEEF, 0));
      directed.push_back(make_cmd(CMD_LDPROG, 50, 0, 32'h1234_5678, 0));
      directed.push_back(make_cmd(CMD_LDPROG, 2, 0, 32'hFFFF_FFFF, 0));
      directed.push_back(make_cmd(CMD_LOAD, 0, 255, 0, 0));
      directed.push_back(make_cmd(CMD_UNMAP, 1, 0, 0, 0));
      directed.push_back(make_cmd(CMD_MAP, 0, 0, 0, 3));
      directed.push_back(make_cmd(5, 63, 255, '1, 511));
      directed.push_back(make_cmd(6, 0, 0, 0, 0));
      directed.push_back(make_cmd(7, 21, 170, 32'h5555_AAAA, 256));
      foreach (directed[i]) issue_cmd(directed[i]);

      // Random part, with one pause until all responses have drained.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 2) begin
            while (!(issued == accepted && expected_rsps.size() == 0)) @(negedge clock);
         end
         issue_cmd(random_cmd(n));
      end
      stimulus_done = 1;

      while (!(issued == accepted && expected_rsps.size() == 0)) @(posedge clock);
      repeat (300) @(posedge clock);
      $display("Checked %0d responses: %0d ok, %0d no free, %0d too large, %0d out of range.",
               checked, status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
      if (errors == 0 && expected_rsps.size() == 0) begin
         $display("segmented_memory_manager test passed");
      end else begin
         $display("segmented_memory_manager test failed");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #4ms;
      $display("segmented_memory_manager test failed");
      $finish;
   end

endmodule

// ===== segmented_memory_manager.f =====
hw/rtl/smm_pkg.sv
hw/rtl/smm_ctrl.sv
hw/rtl/smm_dpath.sv
hw/rtl/segmented_memory_manager.sv
hw/rtl/smm_checker.sv
test/segmented_memory_manager_test.sv
